[hdl/keypad_code_lock_assert.svh]
// Assertion macros shared by the keypad code lock RTL.
`ifndef KEYPAD_CODE_LOCK_ASSERT_SVH
`define KEYPAD_CODE_LOCK_ASSERT_SVH

// Implication within the same cycle, checked outside reset.
`define KCL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad code lock check failed");

// Implication into the following cycle, checked outside reset.
`define KCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad code lock check failed");

`endif

[hdl/kcl_pkg.sv]
// Constants shared by the keypad code lock design.
package kcl_pkg;

  localparam int KEY_W        = 5;
  localparam int NIBBLE_W     = 4;
  localparam int PASSWORD_W   = 24;
  localparam int MAX_WRONG_W  = 4;
  localparam int TIMEOUT_W    = 8;
  localparam int STATUS_W     = 2;
  localparam int ENTRY_W      = 30;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 24;

  localparam int CODE_LENGTH_DEF = 6;

  // Key codes with a special meaning.
  localparam logic [KEY_W-1:0] KEY_NONE  = 5'd16;
  localparam logic [KEY_W-1:0] KEY_CLEAR = 5'd11;
  localparam logic [KEY_W-1:0] KEY_ENTER = 5'd15;

  // Lock modes, also reported as status.
  localparam logic [STATUS_W-1:0] MODE_ENTERING = 2'd0;
  localparam logic [STATUS_W-1:0] MODE_UNLOCKED = 2'd1;
  localparam logic [STATUS_W-1:0] MODE_LOCKED   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PASSWORD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_WRONG = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [PASSWORD_W-1:0]  PASSWORD_RST  = 24'hC1DD97;
  localparam logic [MAX_WRONG_W-1:0] MAX_WRONG_RST = 4'd3;
  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = 8'd30;

  // Wrong count saturates here.
  localparam logic [MAX_WRONG_W-1:0] WRONG_MAX = 4'hF;

endpackage

[hdl/keypad_code_lock.sv]
// Keypad code lock: key entry, password check, wrong-attempt count and timeout.
// A result beat is registered in the cycle after its poll beat is accepted.
// Throughput: one poll per cycle; the single result register is the only stage,
// and a poll is taken whenever that register is empty or being drained.
// Reset (rst_n low, synchronous) restores the default password, limits, a blank
// entry, zero counts and entering mode, and empties the result register.
module keypad_code_lock #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [kcl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Poll input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kcl_pkg::KEY_W-1:0]        in_key_code,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [kcl_pkg::STATUS_W-1:0]     out_status,
  output logic [kcl_pkg::ENTRY_W-1:0]      out_entry_keys,
  output logic [kcl_pkg::MAX_WRONG_W-1:0]  out_wrong_count,
  output logic [kcl_pkg::TIMEOUT_W-1:0]    out_countdown
);
  import kcl_pkg::*;

  // Packed width of the entry, and the password widened so that every key
  // position has a nibble (positions above the 24 stored bits read as zero).
  localparam int PACK_W = CODE_LENGTH * KEY_W;
  localparam int PW_EXT_W = CODE_LENGTH * NIBBLE_W + PASSWORD_W;

  // Configuration registers.
  logic [PASSWORD_W-1:0]  password_r;
  logic [MAX_WRONG_W-1:0] max_wrong_r;
  logic [TIMEOUT_W-1:0]   timeout_r;

  // Lock state.
  logic [KEY_W-1:0]       prev_key_r;
  logic [KEY_W-1:0]       entry_r [CODE_LENGTH];
  logic [MAX_WRONG_W-1:0] wrong_r;
  logic [TIMEOUT_W-1:0]   tick_r;
  logic [STATUS_W-1:0]    mode_r;

  logic [KEY_W-1:0]       prev_key_nxt;
  logic [KEY_W-1:0]       entry_nxt [CODE_LENGTH];
  logic [MAX_WRONG_W-1:0] wrong_nxt;
  logic [TIMEOUT_W-1:0]   tick_nxt;
  logic [STATUS_W-1:0]    mode_nxt;

  // Result register.
  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [ENTRY_W-1:0]     out_entry_r;
  logic [MAX_WRONG_W-1:0] out_wrong_r;
  logic [TIMEOUT_W-1:0]   out_countdown_r;

  logic                   in_fire;
  logic                   key_acted;
  logic                   code_match;
  logic [PW_EXT_W-1:0]    pw_ext;
  logic [PACK_W-1:0]      entry_packed;
  logic [PACK_W+ENTRY_W-1:0] entry_wide;
  logic [TIMEOUT_W-1:0]   countdown_nxt;

  // A new poll is taken whenever the result register is free or is being
  // drained in this very cycle, so polls stream at one per cycle.
  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  // A key is acted on only when it is a real key (below 16) and differs
  // from the previous poll, which filters out a held key.
  assign key_acted = (in_key_code != prev_key_r) && (in_key_code[KEY_W-1] == 1'b0);

  assign pw_ext = {{(CODE_LENGTH * NIBBLE_W){1'b0}}, password_r};

  // The entry matches when every slot holds its password nibble. A blank slot
  // has the top bit set, so it never matches and a short entry is wrong.
  always_comb begin
    code_match = 1'b1;
    for (int k = 0; k < CODE_LENGTH; k++) begin
      if (entry_r[k] != {1'b0, pw_ext[NIBBLE_W*(CODE_LENGTH-1-k) +: NIBBLE_W]}) begin
        code_match = 1'b0;
      end
    end
  end

  // Next state for one poll. Unlocked and locked-forever freeze everything,
  // the previous key included.
  always_comb begin
    prev_key_nxt = prev_key_r;
    entry_nxt    = entry_r;
    wrong_nxt    = wrong_r;
    tick_nxt     = tick_r;
    mode_nxt     = mode_r;
    if (mode_r == MODE_ENTERING) begin
      if (key_acted) begin
        priority if (in_key_code == KEY_CLEAR) begin
          for (int k = 0; k < CODE_LENGTH; k++) begin
            entry_nxt[k] = KEY_NONE;
          end
        end else if (in_key_code == KEY_ENTER) begin
          if (code_match) begin
            mode_nxt = MODE_UNLOCKED;
          end else if (wrong_r != WRONG_MAX) begin
            wrong_nxt = wrong_r + 1'b1;
          end
        end else begin
          // Oldest key drops out at slot zero; the new key lands at the end.
          for (int k = 0; k < CODE_LENGTH - 1; k++) begin
            entry_nxt[k] = entry_r[k+1];
          end
          entry_nxt[CODE_LENGTH-1] = in_key_code;
        end
        // Any acted-on key checks the limit, so a limit of zero locks at once.
        if (mode_nxt == MODE_ENTERING && wrong_nxt == max_wrong_r) begin
          mode_nxt = MODE_LOCKED;
        end
      end
      prev_key_nxt = in_key_code;
      // The timer keeps running on the locking poll too. Once it has reached
      // the timeout, the next poll clears it and the wrong count instead.
      if (mode_nxt != MODE_UNLOCKED) begin
        if (tick_r < timeout_r) begin
          tick_nxt = tick_r + 1'b1;
        end else begin
          wrong_nxt = '0;
          tick_nxt  = '0;
        end
      end
    end
  end

  // Report the entry oldest-first from the top, trimmed or padded to 30 bits.
  always_comb begin
    entry_packed = '0;
    for (int k = 0; k < CODE_LENGTH; k++) begin
      entry_packed[KEY_W*(CODE_LENGTH-1-k) +: KEY_W] = entry_nxt[k];
    end
  end

  assign entry_wide    = {{ENTRY_W{1'b0}}, entry_packed};
  assign countdown_nxt = (tick_nxt < timeout_r) ? (timeout_r - tick_nxt) : '0;

  // Configuration writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      password_r  <= PASSWORD_RST;
      max_wrong_r <= MAX_WRONG_RST;
      timeout_r   <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PASSWORD:  password_r  <= cfg_wdata[PASSWORD_W-1:0];
        REG_MAX_WRONG: max_wrong_r <= cfg_wdata[MAX_WRONG_W-1:0];
        REG_TIMEOUT:   timeout_r   <= cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Lock state advances on every accepted poll beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_key_r <= '0;
      for (int k = 0; k < CODE_LENGTH; k++) begin
        entry_r[k] <= KEY_NONE;
      end
      wrong_r <= '0;
      tick_r  <= '0;
      mode_r  <= MODE_ENTERING;
    end else if (in_fire) begin
      prev_key_r <= prev_key_nxt;
      entry_r    <= entry_nxt;
      wrong_r    <= wrong_nxt;
      tick_r     <= tick_nxt;
      mode_r     <= mode_nxt;
    end
  end

  // Result register: loads with each poll, empties when its beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r    <= mode_nxt;
      out_entry_r     <= entry_wide[ENTRY_W-1:0];
      out_wrong_r     <= wrong_nxt;
      out_countdown_r <= countdown_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_keys  = out_entry_r;
  assign out_wrong_count = out_wrong_r;
  assign out_countdown   = out_countdown_r;

  `include "keypad_code_lock_assert.svh"

  // Unlocked and locked-forever hold until reset.
  `KCL_ASSERT_NEXT(a_terminal_holds, (mode_r == MODE_UNLOCKED || mode_r == MODE_LOCKED), $stable(mode_r))
  // Every accepted poll leaves a result beat that reports the new mode.
  `KCL_ASSERT_NEXT(a_result_tracks_mode, in_fire, out_valid_r && out_status_r == mode_r)
  // While unlocked the timer and wrong count are frozen.
  `KCL_ASSERT_NEXT(a_unlocked_frozen, mode_r == MODE_UNLOCKED, $stable(tick_r) && $stable(wrong_r))
  // A poll is never taken while a waiting result is held back.
  `KCL_ASSERT_SAME(a_no_overrun, out_valid_r && out_stall, !in_fire)

endmodule
